// File: hw/rtl/mrrbd_pkg.sv
// Shared types and constants for the mirrored RAM / ROM bus decoder.
// Depends on nothing; every other file of the block but mrrbd_byte_ram imports it.
package mrrbd_pkg;

  // Memory geometry and window bases.
  localparam int unsigned RAM_BYTES = 65536;
  localparam int unsigned ROM_BYTES = 65536;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
  localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);

  localparam logic [32:0] CACHED_BASE   = 33'h0_8000_0000;
  localparam logic [32:0] UNCACHED_BASE = 33'h0_C000_0000;
  localparam logic [32:0] ROM_BASE      = 33'h0_FFF0_0000;
  localparam logic [32:0] RAM_SIZE_MAX  = 33'(RAM_BYTES);
  localparam logic [32:0] ROM_SIZE_MAX  = 33'(ROM_BYTES);

  // Reservations are tracked per 32-byte granule.
  localparam logic [31:0] GRANULE_MASK = 32'hFFFF_FFE0;

  // Width of the size registers.
  localparam int unsigned CFG_W = 17;

  // Register index of each size register (byte address bit 2).
  localparam logic REG_RAM_BYTES = 1'b0;
  localparam logic REG_ROM_BYTES = 1'b1;

  // Transaction kinds.
  localparam logic [1:0] ACT_READ     = 2'd0;
  localparam logic [1:0] ACT_WRITE    = 2'd1;
  localparam logic [1:0] ACT_RESERVE  = 2'd2;
  localparam logic [1:0] ACT_ROM_LOAD = 2'd3;

  // Result source codes.
  localparam logic [1:0] SRC_RAM    = 2'd0;
  localparam logic [1:0] SRC_ROM    = 2'd1;
  localparam logic [1:0] SRC_DEVICE = 2'd2;
  localparam logic [1:0] SRC_NONE   = 2'd3;

  // Address decode outcome handed from the decoder to the sequencer.
  typedef struct packed {
    logic              ram_ok;
    logic [RAM_AW-1:0] ram_off;
    logic              rom_ok;
    logic [ROM_AW-1:0] rom_off;
    logic              load_ok;
    logic [ROM_AW-1:0] load_off;
  } dec_t;

endpackage

// File: hw/rtl/mirrored_ram_rom_bus_decoder.sv
// Top level of the mirrored RAM / ROM bus decoder: APB registers and byte sequencer.
// Depends on mrrbd_pkg, mrrbd_decode and mrrbd_byte_ram.
//
// Channel   Handshake                       Payload
// request   start && !busy                  action_i address_i size_code_i
//                                           write_data_i instr_addr_i
// result    done_o, one cycle               read_data_o source_o device_request_o
//                                           device_is_write_o device_pc_o
//                                           reservation_cleared_o
// config    psel && penable && pwrite       paddr pwdata (pready always high)
//
// A transaction passes through a decode state, then a read or a RAM write moves one
// byte per cycle through the RAM or ROM store; all other transactions finish in
// the decode state.
// busy is high from acceptance until the result strobe; the strobe cycle can
// accept the next transaction. Results cannot be stalled by the receiver.
// Reset clears the reservation and loads the size registers; store contents
// are undefined until written.
module mirrored_ram_rom_bus_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [1:0]  size_code_i,
  input  logic [63:0] write_data_i,
  input  logic [31:0] instr_addr_i,
  // Result channel
  output logic        done_o,
  output logic [63:0] read_data_o,
  output logic [1:0]  source_o,
  output logic        device_request_o,
  output logic        device_is_write_o,
  output logic [31:0] device_pc_o,
  output logic        reservation_cleared_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrrbd_pkg::*;

  localparam int unsigned OFF_W = (RAM_AW > ROM_AW) ? RAM_AW : ROM_AW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_WRITE
  } state_e;

  state_e             state_q;
  logic [CFG_W-1:0]   ram_cfg_q;
  logic [CFG_W-1:0]   rom_cfg_q;
  logic [1:0]         act_q;
  logic [31:0]        addr_q;
  logic [1:0]         size_q;
  logic [63:0]        wdata_q;
  logic [31:0]        pc_q;
  logic [OFF_W-1:0]   off_q;
  logic               use_rom_q;
  logic [3:0]         cnt_q;
  logic               pend_q;
  logic [63:0]        shift_q;
  logic               rclr_q;
  logic               res_valid_q;
  logic [31:0]        res_addr_q;
  logic               done_q;
  logic [63:0]        rdata_q;
  logic [1:0]         src_q;
  logic               dreq_q;
  logic               dwr_q;
  logic [31:0]        dpc_q;
  logic               rclr_out_q;

  dec_t               dec;
  logic [3:0]         need;
  logic [2:0]         wsel;
  logic               rd_issue;
  logic               cfg_wr;
  logic               clr_hit;
  logic               ram_we;
  logic               ram_re;
  logic [RAM_AW-1:0]  ram_addr;
  logic [7:0]         ram_rdata;
  logic               rom_we;
  logic               rom_re;
  logic [ROM_AW-1:0]  rom_raddr;
  logic [7:0]         rom_rdata;
  logic [7:0]         wbyte;
  logic [7:0]         rd_byte;
  logic [63:0]        rd_word;

  // Address decode of the held transaction.
  mrrbd_decode u_decode (
    .addr_i      (addr_q),
    .size_code_i (size_q),
    .ram_cfg_i   (ram_cfg_q),
    .rom_cfg_i   (rom_cfg_q),
    .dec_o       (dec)
  );

  // Byte sequencing: address of the current byte and big-endian byte lane.
  always_comb begin
    need      = 4'd1 << size_q;
    wsel      = 3'(need - 4'd1 - cnt_q);
    wbyte     = wdata_q[8*wsel +: 8];
    rd_issue  = (state_q == ST_READ) && (cnt_q < need);
    ram_addr  = off_q[RAM_AW-1:0] + RAM_AW'(cnt_q[2:0]);
    rom_raddr = off_q[ROM_AW-1:0] + ROM_AW'(cnt_q[2:0]);
    ram_we    = (state_q == ST_WRITE);
    ram_re    = rd_issue && !use_rom_q;
    rom_re    = rd_issue && use_rom_q;
    rom_we    = (state_q == ST_DECODE) && (act_q == ACT_ROM_LOAD) && dec.load_ok;
    rd_byte   = use_rom_q ? rom_rdata : ram_rdata;
    rd_word   = {shift_q[55:0], rd_byte};
    clr_hit   = res_valid_q && (((res_addr_q ^ addr_q) & GRANULE_MASK) == 32'd0);
    cfg_wr    = psel && penable && pwrite && pready;
  end

  mrrbd_byte_ram #(.AW(RAM_AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (wbyte),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  mrrbd_byte_ram #(.AW(ROM_AW)) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .waddr_i (dec.load_off),
    .wdata_i (wdata_q[7:0]),
    .re_i    (rom_re),
    .raddr_i (rom_raddr),
    .rdata_o (rom_rdata)
  );

  // Sequencer, configuration registers, reservation and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ram_cfg_q   <= CFG_W'(RAM_BYTES);
      rom_cfg_q   <= '0;
      act_q       <= '0;
      addr_q      <= '0;
      size_q      <= '0;
      wdata_q     <= '0;
      pc_q        <= '0;
      off_q       <= '0;
      use_rom_q   <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      shift_q     <= '0;
      rclr_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_addr_q  <= '0;
      done_q      <= 1'b0;
      rdata_q     <= '0;
      src_q       <= SRC_NONE;
      dreq_q      <= 1'b0;
      dwr_q       <= 1'b0;
      dpc_q       <= '0;
      rclr_out_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_ROM_BYTES) begin
          rom_cfg_q <= pwdata[CFG_W-1:0];
        end else begin
          ram_cfg_q <= pwdata[CFG_W-1:0];
        end
      end

      case (state_q)
        // The result strobe raised on entry to this state lasts one cycle.
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            act_q   <= action_i;
            addr_q  <= address_i;
            size_q  <= size_code_i;
            wdata_q <= write_data_i;
            pc_q    <= instr_addr_i;
            state_q <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          cnt_q   <= '0;
          pend_q  <= 1'b0;
          shift_q <= '0;
          rdata_q <= '0;
          dreq_q  <= 1'b0;
          dwr_q   <= 1'b0;
          dpc_q   <= '0;
          rclr_out_q <= 1'b0;
          case (act_q)
            ACT_READ: begin
              if (dec.ram_ok) begin
                off_q     <= OFF_W'(dec.ram_off);
                use_rom_q <= 1'b0;
                state_q   <= ST_READ;
              end else if (dec.rom_ok) begin
                off_q     <= OFF_W'(dec.rom_off);
                use_rom_q <= 1'b1;
                state_q   <= ST_READ;
              end else begin
                src_q   <= SRC_DEVICE;
                dreq_q  <= 1'b1;
                dpc_q   <= pc_q;
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
            end
            ACT_WRITE: begin
              if (dec.ram_ok) begin
                off_q   <= OFF_W'(dec.ram_off);
                rclr_q  <= clr_hit;
                if (clr_hit) begin
                  res_valid_q <= 1'b0;
                end
                state_q <= ST_WRITE;
              end else begin
                src_q   <= SRC_DEVICE;
                dreq_q  <= 1'b1;
                dwr_q   <= 1'b1;
                dpc_q   <= pc_q;
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
            end
            ACT_RESERVE: begin
              res_valid_q <= 1'b1;
              res_addr_q  <= addr_q;
              src_q       <= SRC_NONE;
              done_q      <= 1'b1;
              state_q     <= ST_IDLE;
            end
            default: begin
              // ROM byte load: the store write happens during this cycle.
              src_q   <= SRC_NONE;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          endcase
        end

        // One address issued per cycle; data returns from the registered read port in the next cycle.
        ST_READ: begin
          cnt_q  <= cnt_q + {3'd0, rd_issue};
          pend_q <= rd_issue;
          if (pend_q) begin
            shift_q <= rd_word;
          end
          if (pend_q && !rd_issue) begin
            rdata_q <= rd_word;
            src_q   <= use_rom_q ? SRC_ROM : SRC_RAM;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end

        ST_WRITE: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == need - 4'd1) begin
            src_q      <= SRC_RAM;
            rclr_out_q <= rclr_q;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Register read-back and port assignments.
  assign prdata = (paddr[2] == REG_ROM_BYTES) ? 32'(rom_cfg_q) : 32'(ram_cfg_q);
  assign pready = 1'b1;
  assign busy   = (state_q != ST_IDLE);

  assign done_o                = done_q;
  assign read_data_o           = rdata_q;
  assign source_o              = src_q;
  assign device_request_o      = dreq_q;
  assign device_is_write_o     = dwr_q;
  assign device_pc_o           = dpc_q;
  assign reservation_cleared_o = rclr_out_q;

endmodule

// File: hw/rtl/mrrbd_byte_ram.sv
// Byte-wide synchronous memory with one write port and one registered read port.
// Depends on nothing; used for both the RAM and the ROM store.
module mrrbd_byte_ram #(
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mrrbd_decode.sv
// Window decoder: checks the three RAM aliases, the ROM window and the ROM load range.
// Depends on mrrbd_pkg for bases, sizes and the decode struct.
module mrrbd_decode (
  input  logic [31:0]                 addr_i,
  input  logic [1:0]                  size_code_i,
  input  logic [mrrbd_pkg::CFG_W-1:0] ram_cfg_i,
  input  logic [mrrbd_pkg::CFG_W-1:0] rom_cfg_i,
  output mrrbd_pkg::dec_t             dec_o
);
  import mrrbd_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        fit;
    logic [32:0] off;
  } win_t;

  // Checks whether the access starts in [base, base+size) and fits in it.
  function automatic win_t window(input logic [31:0] addr, input logic [32:0] base,
                                  input logic [32:0] size, input logic [32:0] need);
    win_t w;
    logic [32:0] a;
    a     = {1'b0, addr};
    w.off = a - base;
    w.hit = (a >= base) && (w.off < size);
    w.fit = w.hit && ((w.off + need) <= size);
    return w;
  endfunction

  logic [32:0] need;
  logic [32:0] ram_sz;
  logic [32:0] rom_sz;
  win_t        w_cached;
  win_t        w_uncached;
  win_t        w_low;
  win_t        w_rom;
  logic [31:0] load_ofs;

  // Clamp the configured sizes to the physical stores.
  assign need   = 33'd1 << size_code_i;
  assign ram_sz = (33'(ram_cfg_i) > RAM_SIZE_MAX) ? RAM_SIZE_MAX : 33'(ram_cfg_i);
  assign rom_sz = (33'(rom_cfg_i) > ROM_SIZE_MAX) ? ROM_SIZE_MAX : 33'(rom_cfg_i);

  assign w_cached   = window(addr_i, CACHED_BASE, ram_sz, need);
  assign w_uncached = window(addr_i, UNCACHED_BASE, ram_sz, need);
  assign w_low      = window(addr_i, 33'd0, ram_sz, need);
  assign w_rom      = window(addr_i, ROM_BASE, rom_sz, need);

  // The ROM load offset wraps modulo 2^32.
  assign load_ofs = addr_i - ROM_BASE[31:0];

  // The first alias that holds the start address decides the RAM outcome.
  always_comb begin
    dec_o = '0;
    if (w_cached.hit) begin
      dec_o.ram_ok  = w_cached.fit;
      dec_o.ram_off = w_cached.off[RAM_AW-1:0];
    end else if (w_uncached.hit) begin
      dec_o.ram_ok  = w_uncached.fit;
      dec_o.ram_off = w_uncached.off[RAM_AW-1:0];
    end else if (w_low.hit) begin
      dec_o.ram_ok  = w_low.fit;
      dec_o.ram_off = w_low.off[RAM_AW-1:0];
    end
    dec_o.rom_ok   = w_rom.fit;
    dec_o.rom_off  = w_rom.off[ROM_AW-1:0];
    dec_o.load_ok  = (33'(load_ofs) < ROM_SIZE_MAX);
    dec_o.load_off = load_ofs[ROM_AW-1:0];
  end

endmodule

// File: verif/mirrored_ram_rom_bus_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the mirrored RAM / ROM bus decoder: snoops the register port and both
// channels, predicts every result and compares it field by field. Uses mrrbd_pkg.
module mirrored_ram_rom_bus_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [1:0]  size_code_i,
  input  logic [63:0] write_data_i,
  input  logic [31:0] instr_addr_i,
  // Result channel
  input  logic        done_i,
  input  logic [63:0] read_data_i,
  input  logic [1:0]  source_i,
  input  logic        device_request_i,
  input  logic        device_is_write_i,
  input  logic [31:0] device_pc_i,
  input  logic        reservation_cleared_i,
  // Configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // Status for the test top
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);
  import mrrbd_pkg::*;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  source;
    logic        dev_req;
    logic        dev_wr;
    logic [31:0] dev_pc;
    logic        resv_clr;
  } bus_result_t;

  // Mirror of the block's registers and stores.
  logic [CFG_W-1:0] ram_cfg;
  logic [CFG_W-1:0] rom_cfg;
  logic [7:0]       ram_image [RAM_BYTES];
  logic [7:0]       rom_image [ROM_BYTES];
  logic             resv_valid;
  logic [31:0]      resv_addr;
  bus_result_t      expected_q [$];
  int unsigned      mismatches;

  // Says whether nbytes bytes from addr fit in [base, base + span), without wraparound.
  function automatic logic window_fit(input logic [31:0] addr, input logic [32:0] base,
      input logic [32:0] span, input int unsigned nbytes, output logic in_win,
      output logic [31:0] offset);
    logic [32:0] wide;
    wide = {1'b0, addr};
    in_win = (wide >= base) && (wide < base + span);
    offset = 32'(wide - base);
    return in_win && ((span - (wide - base)) >= 33'(nbytes));
  endfunction

  // The first alias whose window holds the start address decides the outcome.
  function automatic logic ram_lookup(input logic [31:0] addr, input int unsigned nbytes,
      output logic [31:0] offset);
    logic [32:0] bases [3];
    logic [32:0] span;
    logic        in_win;
    logic        fits;
    bases = '{CACHED_BASE, UNCACHED_BASE, 33'h0};
    span = (33'(ram_cfg) > RAM_SIZE_MAX) ? RAM_SIZE_MAX : 33'(ram_cfg);
    offset = '0;
    for (int b = 0; b < 3; b++) begin
      fits = window_fit(addr, bases[b], span, nbytes, in_win, offset);
      if (in_win) return fits;
    end
    return 1'b0;
  endfunction

  // Computes the result of one transaction and updates the mirrored state.
  function automatic bus_result_t predict_access(input logic [1:0] act,
      input logic [31:0] addr, input logic [1:0] size_code, input logic [63:0] wdata,
      input logic [31:0] pc);
    bus_result_t res;
    int unsigned nbytes;
    logic [31:0] offset;
    logic [32:0] rom_span;
    logic        in_win;
    nbytes = 1 << size_code;
    res = '0;
    res.source = SRC_NONE;
    rom_span = (33'(rom_cfg) > ROM_SIZE_MAX) ? ROM_SIZE_MAX : 33'(rom_cfg);
    case (act)
      ACT_READ: begin
        if (ram_lookup(addr, nbytes, offset)) begin
          for (int i = 0; i < nbytes; i++)
            res.read_data = {res.read_data[55:0],
                             ram_image[RAM_AW'(offset + 32'(i))]};
          res.source = SRC_RAM;
        end else if (window_fit(addr, ROM_BASE, rom_span, nbytes, in_win, offset)) begin
          for (int i = 0; i < nbytes; i++)
            res.read_data = {res.read_data[55:0],
                             rom_image[ROM_AW'(offset + 32'(i))]};
          res.source = SRC_ROM;
        end else begin
          res.source = SRC_DEVICE;
          res.dev_req = 1'b1;
          res.dev_pc = pc;
        end
      end
      ACT_WRITE: begin
        if (ram_lookup(addr, nbytes, offset)) begin
          // Raw addresses are compared, so another alias leaves the reservation alone.
          if (resv_valid && (((resv_addr ^ addr) & GRANULE_MASK) == 32'h0)) begin
            resv_valid = 1'b0;
            res.resv_clr = 1'b1;
          end
          for (int i = 0; i < nbytes; i++)
            ram_image[RAM_AW'(offset + 32'(i))] = wdata[8 * (nbytes - 1 - i) +: 8];
          res.source = SRC_RAM;
        end else begin
          res.source = SRC_DEVICE;
          res.dev_req = 1'b1;
          res.dev_wr = 1'b1;
          res.dev_pc = pc;
        end
      end
      ACT_RESERVE: begin
        resv_valid = 1'b1;
        resv_addr = addr;
      end
      default: begin
        // ROM load: the offset wraps, and anything past the store is dropped.
        offset = addr - ROM_BASE[31:0];
        if (offset < ROM_BYTES) rom_image[ROM_AW'(offset)] = wdata[7:0];
      end
    endcase
    return res;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string what, input logic [63:0] got,
      input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t checker: %s got %h expected %h", $time, what, got, want);
  endtask

  // Results are compared before the new transaction of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    if (!rst_ni) begin
      ram_cfg = CFG_W'(RAM_BYTES);
      rom_cfg = '0;
      resv_valid = 1'b0;
      resv_addr = '0;
      expected_q.delete();
      mismatches = 0;
      outstanding_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding", read_data_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (read_data_i !== want.read_data)
            report_mismatch("read_data", read_data_i, want.read_data);
          if (source_i !== want.source)
            report_mismatch("source", 64'(source_i), 64'(want.source));
          if (device_request_i !== want.dev_req)
            report_mismatch("device_request", 64'(device_request_i), 64'(want.dev_req));
          if (device_is_write_i !== want.dev_wr)
            report_mismatch("device_is_write", 64'(device_is_write_i), 64'(want.dev_wr));
          if (device_pc_i !== want.dev_pc)
            report_mismatch("device_pc", 64'(device_pc_i), 64'(want.dev_pc));
          if (reservation_cleared_i !== want.resv_clr)
            report_mismatch("reservation_cleared", 64'(reservation_cleared_i),
                            64'(want.resv_clr));
        end
      end
      // Register writes land at the access phase.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_RAM_BYTES) begin
          ram_cfg = pwdata_i[CFG_W-1:0];
        end else begin
          rom_cfg = pwdata_i[CFG_W-1:0];
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_access(action_i, address_i, size_code_i,
                                            write_data_i, instr_addr_i));
      outstanding_o <= expected_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// File: verif/mirrored_ram_rom_bus_decoder_tb.sv
`timescale 1ns / 1ps
// Test top for the mirrored RAM / ROM bus decoder: clock, reset, register writes and
// transaction stimulus. Depends on mrrbd_pkg, the block and its checker module.
module mirrored_ram_rom_bus_decoder_tb;
  import mrrbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 215;
  localparam int unsigned RAM_HOT_BYTES   = 512;
  localparam int unsigned ROM_HOT_BYTES   = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  action_i;
  logic [31:0] address_i;
  logic [1:0]  size_code_i;
  logic [63:0] write_data_i;
  logic [31:0] instr_addr_i;
  logic        done_o;
  logic [63:0] read_data_o;
  logic [1:0]  source_o;
  logic        device_request_o;
  logic        device_is_write_o;
  logic [31:0] device_pc_o;
  logic        reservation_cleared_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned mismatches;
  int unsigned outstanding;

  // Stimulus-side view: sizes in force and which store bytes hold data.
  logic [CFG_W-1:0] ram_size_cfg;
  logic [CFG_W-1:0] rom_size_cfg;
  bit               ram_written [RAM_BYTES];
  bit               rom_written [ROM_BYTES];
  logic             steady;
  int unsigned      cycle_count;

  mirrored_ram_rom_bus_decoder i_dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .address_i, .size_code_i, .write_data_i,
    .instr_addr_i, .done_o, .read_data_o, .source_o, .device_request_o,
    .device_is_write_o, .device_pc_o, .reservation_cleared_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mirrored_ram_rom_bus_decoder_checker i_checker (
    .clk_i, .rst_ni,
    .start_i(start), .busy_i(busy), .action_i, .address_i, .size_code_i,
    .write_data_i, .instr_addr_i,
    .done_i(done_o), .read_data_i(read_data_o), .source_i(source_o),
    .device_request_i(device_request_o), .device_is_write_i(device_is_write_o),
    .device_pc_i(device_pc_o), .reservation_cleared_i(reservation_cleared_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic logic [32:0] clamp_span(input logic [CFG_W-1:0] sz,
      input logic [32:0] most);
    return (33'(sz) > most) ? most : 33'(sz);
  endfunction

  function automatic logic fits_window(input logic [31:0] addr, input int unsigned nbytes,
      input logic [32:0] base, input logic [32:0] span, output logic [31:0] off);
    logic [32:0] wide;
    wide = {1'b0, addr};
    off = 32'(wide - base);
    return (wide >= base) && (wide < base + span) && ((span - (wide - base)) >= 33'(nbytes));
  endfunction

  // The aliases never overlap, so whichever one fits is the one that is used.
  function automatic logic ram_target(input logic [31:0] addr, input int unsigned nbytes,
      output logic [31:0] off);
    logic [32:0] span;
    span = clamp_span(ram_size_cfg, RAM_SIZE_MAX);
    if (fits_window(addr, nbytes, CACHED_BASE, span, off)) return 1'b1;
    if (fits_window(addr, nbytes, UNCACHED_BASE, span, off)) return 1'b1;
    return fits_window(addr, nbytes, 33'h0, span, off);
  endfunction

  // Mostly a small hot region, then the window end, then anywhere in the store.
  function automatic logic [31:0] window_pick(input logic [31:0] base, input logic [32:0] span,
      input int unsigned hot, input int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return base + $urandom_range(hot - 1);
    if (roll < 85 && span >= 33'd16) return base + span[31:0] - $urandom_range(1, 16);
    return base + $urandom_range(limit - 1);
  endfunction

  function automatic logic [31:0] ram_pick();
    logic [31:0] base;
    case ($urandom_range(2))
      0:       base = CACHED_BASE[31:0];
      1:       base = UNCACHED_BASE[31:0];
      default: base = 32'h0;
    endcase
    return window_pick(base, clamp_span(ram_size_cfg, RAM_SIZE_MAX), RAM_HOT_BYTES, RAM_BYTES);
  endfunction

  function automatic logic [31:0] rom_pick();
    return window_pick(ROM_BASE[31:0], clamp_span(rom_size_cfg, ROM_SIZE_MAX), ROM_HOT_BYTES,
                       ROM_BYTES);
  endfunction

  // Issues one transaction and returns at the edge that accepts it.
  task automatic send(input logic [1:0] act, input logic [31:0] addr,
      input logic [1:0] size_code, input logic [63:0] wdata);
    logic [1:0]  kind;
    logic [31:0] off;
    logic [31:0] start_addr;
    int unsigned nbytes;
    kind = act;
    start_addr = addr;
    nbytes = 1 << size_code;
    // A read may only touch stored bytes; otherwise a store is sent in its place.
    if (kind == ACT_READ) begin
      if (ram_target(start_addr, nbytes, off)) begin
        for (int i = 0; i < nbytes; i++)
          if (!ram_written[RAM_AW'(off + 32'(i))]) kind = ACT_WRITE;
      end else if (fits_window(start_addr, nbytes, ROM_BASE,
                               clamp_span(rom_size_cfg, ROM_SIZE_MAX), off)) begin
        for (int i = 0; i < nbytes; i++)
          if (kind == ACT_READ && !rom_written[ROM_AW'(off + 32'(i))]) begin
            kind = ACT_ROM_LOAD;
            addr = start_addr + 32'(i);
          end
      end
    end
    if (kind == ACT_WRITE && ram_target(addr, nbytes, off)) begin
      for (int i = 0; i < nbytes; i++) ram_written[RAM_AW'(off + 32'(i))] = 1'b1;
    end
    if (kind == ACT_ROM_LOAD) begin
      off = addr - ROM_BASE[31:0];
      if (off < ROM_BYTES) rom_written[ROM_AW'(off)] = 1'b1;
    end
    if (!steady && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= kind;
    address_i <= addr;
    size_code_i <= size_code;
    write_data_i <= wdata;
    instr_addr_i <= $urandom();
    do @(posedge clk_i); while (busy);
  endtask

  // Holds off until every outstanding transaction has produced its result.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [CFG_W-1:0] value);
    logic [31:0] junk;
    junk = $urandom();
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {junk[31:CFG_W], value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_RAM_BYTES) begin
      ram_size_cfg = value;
    end else begin
      rom_size_cfg = value;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] ram_plan [N_PHASES];
    logic [CFG_W-1:0] rom_plan [N_PHASES];
    logic [31:0]      addr;
    logic [63:0]      wdata;
    logic [1:0]       size_code;
    int unsigned      roll;
    int unsigned      sel;
    ram_plan = '{17'h10000, 17'h1FFFF, 17'd256, 17'h0, 17'd1000, 17'h0, 17'h10000, 17'hFFFF};
    rom_plan = '{17'h10000, 17'h1FFFF, 17'd64, 17'h0, 17'hFFFF, 17'h0, 17'd8, 17'd1};
    ram_plan[5] = CFG_W'($urandom_range(17'h1FFFF));
    rom_plan[5] = CFG_W'($urandom_range(17'h1FFFF));
    ram_size_cfg = CFG_W'(RAM_BYTES);
    rom_size_cfg = '0;
    steady = 1'b0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    action_i <= ACT_READ;
    address_i <= '0;
    size_code_i <= '0;
    write_data_i <= '0;
    instr_addr_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every alias, window ends, reservations, ROM loads and device misses.
    send(ACT_WRITE, CACHED_BASE[31:0], 2'd3, 64'h0123_4567_89AB_CDEF);
    send(ACT_READ, CACHED_BASE[31:0], 2'd3, '0);
    send(ACT_READ, UNCACHED_BASE[31:0] + 32'd3, 2'd0, '0);
    send(ACT_READ, 32'd6, 2'd1, '0);
    send(ACT_READ, CACHED_BASE[31:0] + 32'd4, 2'd2, '0);
    send(ACT_WRITE, UNCACHED_BASE[31:0] + 32'd65528, 2'd3, '1);
    send(ACT_READ, 32'd65528, 2'd3, '0);
    send(ACT_WRITE, CACHED_BASE[31:0] + 32'd65532, 2'd3, '1);
    send(ACT_READ, UNCACHED_BASE[31:0] + 32'd65535, 2'd1, '0);
    send(ACT_RESERVE, CACHED_BASE[31:0] + 32'h40, 2'd0, '0);
    send(ACT_WRITE, UNCACHED_BASE[31:0] + 32'h40, 2'd2, 64'h1111_2222);
    send(ACT_WRITE, CACHED_BASE[31:0] + 32'h5F, 2'd0, 64'h33);
    send(ACT_READ, 32'hFFFF_FFFF, 2'd3, '0);
    send(ACT_WRITE, 32'hFFFF_FFFF, 2'd0, '0);
    for (int i = 0; i < 4; i++)
      send(ACT_ROM_LOAD, ROM_BASE[31:0] + 32'(i), 2'd0, {$urandom(), $urandom()});
    send(ACT_ROM_LOAD, 32'h0, 2'd0, 64'h5A);
    send(ACT_ROM_LOAD, ROM_BASE[31:0] + ROM_BYTES, 2'd0, 64'hA5);
    send(ACT_READ, ROM_BASE[31:0], 2'd2, '0);
    cfg_write(REG_ROM_BYTES, 17'd4);
    send(ACT_READ, ROM_BASE[31:0], 2'd2, '0);
    send(ACT_READ, ROM_BASE[31:0] + 32'd2, 2'd2, '0);
    cfg_write(REG_RAM_BYTES, 17'h0);
    send(ACT_READ, 32'h0, 2'd0, '0);
    send(ACT_WRITE, 32'h0, 2'd3, '0);

    // Random phases, each under its own pair of window sizes.
    for (int p = 0; p < N_PHASES; p++) begin
      cfg_write(REG_RAM_BYTES, ram_plan[p]);
      cfg_write(REG_ROM_BYTES, rom_plan[p]);
      steady = (p == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        size_code = 2'($urandom_range(3));
        wdata = {$urandom(), $urandom()};
        if (roll < 35) begin
          sel = $urandom_range(99);
          addr = (sel < 60) ? ram_pick() : (sel < 85) ? rom_pick() : $urandom();
          send(ACT_READ, addr, size_code, wdata);
        end else if (roll < 70) begin
          addr = ($urandom_range(9) == 0) ? $urandom() : ram_pick();
          send(ACT_WRITE, addr, size_code, wdata);
        end else if (roll < 80) begin
          addr = ($urandom_range(9) == 0) ? $urandom() : ram_pick();
          send(ACT_RESERVE, addr, size_code, wdata);
          // Half the time a store into the same granule follows the reservation.
          if ($urandom_range(1) == 1)
            send(ACT_WRITE, {addr[31:5], 5'($urandom_range(31))}, 2'($urandom_range(3)),
                 {$urandom(), $urandom()});
        end else begin
          addr = ($urandom_range(9) == 0) ? $urandom() : rom_pick();
          send(ACT_ROM_LOAD, addr, size_code, wdata);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
